// ===== design/wapc_pkg.sv =====
// ============================================================================
// Windowed average capture package
// Shared field widths, result and operation codes, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
package wapc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int WINDOW_W = 7;
    localparam int MAXW_W   = 8;
    localparam int KIND_W   = 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 7'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

    typedef struct packed {
        logic take_sample;
        logic sum_run;
        logic div_load;
        logic div_run;
        logic emit_sample;
        logic take_read;
        logic emit_word;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic sum_done;
        logic div_done;
        logic read_go;
        logic word_last;
        logic out_free;
    } status_t;

endpackage

// ===== design/wapc_ctrl.sv =====
// ============================================================================
// Windowed average capture controller
// Sequences sample averaging (sum, divide, emit), frame reads word by word, and empty reads.
// ============================================================================
module wapc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              opcode,
    output logic              in_stall,
    input  wapc_pkg::status_t status,
    output wapc_pkg::cmd_t    cmd
);
    import wapc_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SUM     = 3'd1;
    localparam logic [2:0] S_DIV     = 3'd2;
    localparam logic [2:0] S_SMP_OUT = 3'd3;
    localparam logic [2:0] S_FRD     = 3'd4;
    localparam logic [2:0] S_FWAIT   = 3'd5;
    localparam logic [2:0] S_EMPTY   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_SAMPLE)
                    begin
                        cmd.take_sample = 1'b1;
                        state_next      = S_SUM;
                    end
                    else
                    begin
                        cmd.take_read = 1'b1;
                        state_next    = status.read_go ? S_FRD : S_EMPTY;
                    end
                end
            end
            S_SUM:
            begin
                cmd.sum_run = 1'b1;
                if (status.sum_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_SMP_OUT;
                end
                else
                begin
                    cmd.div_run = 1'b1;
                end
            end
            S_SMP_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sample = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FRD:
            begin
                state_next = S_FWAIT;
            end
            S_FWAIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_word = 1'b1;
                    state_next    = status.word_last ? S_IDLE : S_FRD;
                end
            end
            S_EMPTY:
            begin
                if (status.out_free)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // At most one result is loaded into the output register per cycle.
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_sample, cmd.emit_word, cmd.emit_empty}))
        else $error("more than one result loaded in a cycle");

    // A result is loaded only when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_sample || cmd.emit_word || cmd.emit_empty) |-> status.out_free)
        else $error("result loaded over a waiting result");

    // An accepted sample always starts the summing pass.
    a_sample_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && opcode == OP_SAMPLE) |=> state_reg == S_SUM)
        else $error("accepted sample did not start summing");

endmodule

// ===== design/wapc_dp.sv =====
// ============================================================================
// Windowed average capture datapath
// Sample ring, running sum, bit-serial divider, ping-pong frame memory and
// the output register.
// ============================================================================
module wapc_dp #(
    parameter int RING_DEPTH  = 64,
    parameter int FRAME_WORDS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  wapc_pkg::cmd_t                   cmd,
    output wapc_pkg::status_t                status,
    input  logic [wapc_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic [wapc_pkg::MAXW_W-1:0]      max_words,
    input  logic                             cfg_wr,
    input  logic [wapc_pkg::WINDOW_W-1:0]    cfg_data,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [wapc_pkg::KIND_W-1:0]      result_kind,
    output logic [wapc_pkg::SAMPLE_W-1:0]    result_value,
    output logic                             frame_completed,
    output logic                             last_word
);
    import wapc_pkg::*;

    localparam int RIW = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int PW  = RIW + 1;
    localparam int SW  = SAMPLE_W + CW;
    localparam int DCW = $clog2(SW + 1);
    localparam int FIW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int FAW = $clog2(2 * FRAME_WORDS);

    // Storage
    logic [SAMPLE_W-1:0] ring_mem  [RING_DEPTH];
    logic [SAMPLE_W-1:0] frame_mem [2 * FRAME_WORDS];
    logic [SAMPLE_W-1:0] ring_q_reg;
    logic [SAMPLE_W-1:0] frame_q_reg;

    // Control state
    logic [RIW-1:0]      wr_idx_reg, wr_idx_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [WINDOW_W-1:0] window_reg, window_next;
    logic [RIW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       issue_left_reg, issue_left_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [DCW-1:0]      dstep_reg, dstep_next;
    logic [FIW-1:0]      pos_reg, pos_next;
    logic                filling_b_reg, filling_b_next;
    logic                a_ready_reg, a_ready_next;
    logic                b_ready_reg, b_ready_next;
    logic                rd_sel_reg, rd_sel_next;
    logic [FIW-1:0]      idx_reg, idx_next;
    logic [FIW-1:0]      n_last_reg, n_last_next;
    logic                out_valid_reg, out_valid_next;

    // Payload state
    logic [SW-1:0]       sum_reg, sum_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [SW-1:0]       quo_reg, quo_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SAMPLE_W-1:0] value_reg, value_next;
    logic                done_reg, done_next;
    logic                last_reg, last_next;

    // Helpers
    logic [RIW-1:0]    wr_idx_inc;
    logic [CW-1:0]     fill_inc;
    logic [CW-1:0]     n_new;
    logic [PW-1:0]     start_sum;
    logic [RIW-1:0]    start_ptr;
    logic [RIW-1:0]    rd_ptr_inc;
    logic              issue;
    logic [CW:0]       trial;
    logic [CW:0]       diff;
    logic              trial_ge;
    logic [MAXW_W-1:0] words_min;
    logic              src_ready;
    logic              frame_end;
    logic [FAW-1:0]    frame_wr_addr;
    logic [FAW-1:0]    frame_rd_addr;
    logic              cfg_ok;

    assign wr_idx_inc = (wr_idx_reg == RIW'(RING_DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
    assign fill_inc   = (fill_reg < CW'(RING_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign n_new      = (10'(fill_inc) < 10'(window_reg)) ? fill_inc : CW'(window_reg);
    assign start_sum  = PW'(wr_idx_inc) + PW'(RING_DEPTH) - PW'(n_new);
    assign start_ptr  = (start_sum >= PW'(RING_DEPTH)) ?
                        RIW'(start_sum - PW'(RING_DEPTH)) : RIW'(start_sum);
    assign rd_ptr_inc = (rd_ptr_reg == RIW'(RING_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign issue      = cmd.sum_run && (issue_left_reg != '0);

    assign trial    = {rem_reg, quo_reg[SW-1]};
    assign diff     = trial - {1'b0, n_reg};
    assign trial_ge = (trial >= {1'b0, n_reg});

    assign words_min = (max_words > MAXW_W'(FRAME_WORDS)) ? MAXW_W'(FRAME_WORDS) : max_words;
    assign src_ready = filling_b_reg ? a_ready_reg : b_ready_reg;
    assign frame_end = (pos_reg == FIW'(FRAME_WORDS - 1));

    assign frame_wr_addr = FAW'(pos_reg) + (filling_b_reg ? FAW'(FRAME_WORDS) : FAW'(0));
    assign frame_rd_addr = FAW'(idx_reg) + (rd_sel_reg ? FAW'(FRAME_WORDS) : FAW'(0));

    assign cfg_ok = (cfg_data != '0) && (10'(cfg_data) <= 10'(RING_DEPTH));

    assign status.sum_done  = (issue_left_reg == '0) && !rd_vld_reg;
    assign status.div_done  = (dstep_reg == '0);
    assign status.read_go   = src_ready && (max_words != '0);
    assign status.word_last = (idx_reg == n_last_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        window_next     = window_reg;
        rd_ptr_next     = rd_ptr_reg;
        issue_left_next = issue_left_reg;
        rd_vld_next     = issue;
        dstep_next      = dstep_reg;
        pos_next        = pos_reg;
        filling_b_next  = filling_b_reg;
        a_ready_next    = a_ready_reg;
        b_ready_next    = b_ready_reg;
        rd_sel_next     = rd_sel_reg;
        idx_next        = idx_reg;
        n_last_next     = n_last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        sum_next        = sum_reg;
        n_next          = n_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        done_next       = done_reg;
        last_next       = last_reg;

        if (cfg_wr && cfg_ok)
        begin
            window_next = cfg_data;
        end

        if (cmd.take_sample)
        begin
            wr_idx_next     = wr_idx_inc;
            fill_next       = fill_inc;
            n_next          = n_new;
            rd_ptr_next     = start_ptr;
            issue_left_next = n_new;
            sum_next        = '0;
        end

        if (issue)
        begin
            rd_ptr_next     = rd_ptr_inc;
            issue_left_next = issue_left_reg - 1'b1;
        end

        if (rd_vld_reg)
        begin
            sum_next = sum_reg + SW'(ring_q_reg);
        end

        if (cmd.div_load)
        begin
            quo_next   = sum_reg;
            rem_next   = '0;
            dstep_next = DCW'(SW);
        end

        if (cmd.div_run)
        begin
            quo_next   = {quo_reg[SW-2:0], trial_ge};
            rem_next   = trial_ge ? diff[CW-1:0] : trial[CW-1:0];
            dstep_next = dstep_reg - 1'b1;
        end

        if (cmd.take_read)
        begin
            rd_sel_next = !filling_b_reg;
            idx_next    = '0;
            n_last_next = FIW'(words_min - 1'b1);
            if (filling_b_reg && a_ready_reg)
            begin
                a_ready_next = 1'b0;
            end
            if (!filling_b_reg && b_ready_reg)
            begin
                b_ready_next = 1'b0;
            end
        end

        if (cmd.emit_sample)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_SAMPLE;
            value_next     = quo_reg[SAMPLE_W-1:0];
            done_next      = frame_end;
            last_next      = 1'b1;
            if (frame_end)
            begin
                pos_next       = '0;
                filling_b_next = !filling_b_reg;
                if (filling_b_reg)
                begin
                    b_ready_next = 1'b1;
                end
                else
                begin
                    a_ready_next = 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end

        if (cmd.emit_word)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_WORD;
            value_next     = frame_q_reg;
            done_next      = 1'b0;
            last_next      = (idx_reg == n_last_reg);
            idx_next       = idx_reg + 1'b1;
        end

        if (cmd.emit_empty)
        begin
            out_valid_next = 1'b1;
            kind_next      = KIND_EMPTY;
            value_next     = '0;
            done_next      = 1'b0;
            last_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            window_reg     <= WINDOW_RESET;
            rd_ptr_reg     <= '0;
            issue_left_reg <= '0;
            rd_vld_reg     <= 1'b0;
            dstep_reg      <= '0;
            pos_reg        <= '0;
            filling_b_reg  <= 1'b0;
            a_ready_reg    <= 1'b0;
            b_ready_reg    <= 1'b0;
            rd_sel_reg     <= 1'b0;
            idx_reg        <= '0;
            n_last_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_idx_reg     <= wr_idx_next;
            fill_reg       <= fill_next;
            window_reg     <= window_next;
            rd_ptr_reg     <= rd_ptr_next;
            issue_left_reg <= issue_left_next;
            rd_vld_reg     <= rd_vld_next;
            dstep_reg      <= dstep_next;
            pos_reg        <= pos_next;
            filling_b_reg  <= filling_b_next;
            a_ready_reg    <= a_ready_next;
            b_ready_reg    <= b_ready_next;
            rd_sel_reg     <= rd_sel_next;
            idx_reg        <= idx_next;
            n_last_reg     <= n_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        n_reg     <= n_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        kind_reg  <= kind_next;
        value_reg <= value_next;
        done_reg  <= done_next;
        last_reg  <= last_next;
    end

    // Sample ring: written on sample accept, read continuously at the sum pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            ring_mem[wr_idx_reg] <= sample_value;
        end
        ring_q_reg <= ring_mem[rd_ptr_reg];
    end

    // Ping-pong frames: buffer A in the lower half, buffer B in the upper half.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_sample)
        begin
            frame_mem[frame_wr_addr] <= quo_reg[SAMPLE_W-1:0];
        end
        frame_q_reg <= frame_mem[frame_rd_addr];
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = kind_reg;
    assign result_value    = value_reg;
    assign frame_completed = done_reg;
    assign last_word       = last_reg;

    // The averaging window never leaves its legal range.
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (window_reg != '0) && (10'(window_reg) <= 10'(RING_DEPTH)))
        else $error("window length out of range");

    // The fill count saturates at the ring depth.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        10'(fill_reg) <= 10'(RING_DEPTH))
        else $error("ring fill count beyond ring depth");

    // Dividing never starts before every ring read has been summed.
    a_div_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_load |-> (!rd_vld_reg && issue_left_reg == '0))
        else $error("divide started with ring reads outstanding");

endmodule

// ===== design/windowed_average_pingpong_capture_top.sv =====
// ============================================================================
// Windowed average ping-pong capture, top level
// Moving-average filter over a sample ring feeding two alternating frame
// buffers that a reader drains on request.
// ============================================================================
// A sample beat (opcode 0) stores the 12-bit sample in a ring of RING_DEPTH
// entries and returns one result: the truncated mean of the newest
// min(samples seen, window_length) samples. That mean is also written into
// the frame buffer being filled; when that buffer holds FRAME_WORDS means it
// is marked ready, frame_completed is set on the result, and filling moves to
// the other buffer. A read beat (opcode 1) streams the ready buffer that is
// not being filled, min(FRAME_WORDS, max_words) words, with last_word on the
// final one, and clears its ready mark. With no ready buffer, or a zero
// max_words, a single empty-read result is returned (a ready buffer is still
// consumed). One item is processed at a time and the input stalls until it is
// finished. The ring is read one entry per cycle for the sum, and the divider
// retires one quotient bit per cycle. Each word of a read passes through
// the registered read of the frame memory. A finished result waits in an
// output register, and the next item may be accepted while it waits. The
// window_length register is written over the configuration port, which is
// always ready; values outside 1 to RING_DEPTH are ignored. Write it only
// while idle.
module windowed_average_pingpong_capture_top #(
    parameter int RING_DEPTH  = 64,
    parameter int FRAME_WORDS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Item input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [wapc_pkg::SAMPLE_W-1:0]    sample_value,
    input  logic [wapc_pkg::MAXW_W-1:0]      max_words,

    // Result output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [wapc_pkg::KIND_W-1:0]      result_kind,
    output logic [wapc_pkg::SAMPLE_W-1:0]    result_value,
    output logic                             frame_completed,
    output logic                             last_word,

    // Configuration write channel for window_length
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [wapc_pkg::WINDOW_W-1:0]    cfg_data
);
    import wapc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The window register is written directly, so every beat is taken.
    assign cfg_ready = 1'b1;

    // The controller decides what happens each cycle; the datapath carries it out.
    wapc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wapc_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .FRAME_WORDS (FRAME_WORDS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .sample_value    (sample_value),
        .max_words       (max_words),
        .cfg_wr          (cfg_valid && cfg_ready),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .result_kind     (result_kind),
        .result_value    (result_value),
        .frame_completed (frame_completed),
        .last_word       (last_word)
    );

endmodule
